// ===== hdl/mi_pkg.sv =====
`timescale 1ns / 1ps

package mi_pkg;

  // default operand width for value, modulus and inverse
  localparam int MI_DATA_WIDTH = 31;

endpackage

// ===== hdl/mi_if.sv =====
`timescale 1ns / 1ps

interface mi_in_if #(
  parameter int DATA_WIDTH = mi_pkg::MI_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mi_out_if #(
  parameter int DATA_WIDTH = mi_pkg::MI_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] inverse;
  logic                  exists;

  modport source (output valid, output inverse, output exists, input ready);
  modport sink   (input valid, input inverse, input exists, output ready);
endinterface

// ===== hdl/mi_div_unit.sv =====
`timescale 1ns / 1ps

module mi_div_unit #(
  parameter int DATA_WIDTH = mi_pkg::MI_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  input  logic [DATA_WIDTH:0]   mult,
  input  logic [DATA_WIDTH:0]   addend,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH:0]   acc
);
  import mi_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] num;
  logic [DATA_WIDTH:0]   trial;
  logic                  ge;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH:0]   acc_next;

  // restoring division, one quotient bit per cycle; each quotient bit also
  // folds mult into acc msb first, so acc ends as quotient * mult + addend
  assign trial    = {rem, num[DATA_WIDTH-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
  assign acc_next = {acc[DATA_WIDTH-1:0], 1'b0} + (ge ? mult : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(DATA_WIDTH));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= dividend;
        rem  <= '0;
        acc  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DATA_WIDTH)) begin
          // last cycle adds the older coefficient
          acc  <= acc + addend;
          busy <= 1'b0;
        end else begin
          rem <= rem_next;
          num <= {num[DATA_WIDTH-2:0], 1'b0};
          acc <= acc_next;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held longer than one cycle");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor)
    else $error("remainder not below divisor");
`endif

endmodule

// ===== hdl/modular_inverse.sv =====
`timescale 1ns / 1ps

// channel  dir  payload                      handshake
// din      in   value, modulus               valid / ready
// dout     out  inverse, exists              valid / ready
//
// one item at a time: each Euclid round runs on the bit-serial
// divide-and-accumulate unit; at most 45 rounds for 31 bits, plus the
// accept, the closing check, the final reduction and the output load.
// synchronous reset clears the sequencer and the output valid flag.
// din.ready is high only when the sequencer is idle; a result waiting on
// dout does not block the next word from being taken.

module modular_inverse #(
  parameter int DATA_WIDTH = mi_pkg::MI_DATA_WIDTH
) (
  input logic     clk,
  input logic     rst,
  mi_in_if.sink   din,
  mi_out_if.source dout
);
  import mi_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_FINAL  = 3'd4;

  logic [2:0]            state;
  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] nr;
  logic [DATA_WIDTH-1:0] m;
  logic [DATA_WIDTH:0]   tmag;
  logic [DATA_WIDTH:0]   ntmag;
  logic                  idx;
  logic [DATA_WIDTH:0]   tmod;

  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_inverse;
  logic                  out_exists;

  logic                  div_start;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [DATA_WIDTH:0]   div_acc;

  logic                  accept;
  logic                  coprime;
  logic [DATA_WIDTH:0]   tsub;
  logic [DATA_WIDTH-1:0] inv_next;

  assign din.ready    = (state == S_IDLE);
  assign accept       = din.valid && din.ready;
  assign dout.valid   = out_valid;
  assign dout.inverse = out_inverse;
  assign dout.exists  = out_exists;

  assign div_start = (state == S_CHECK) && (nr != '0) && (m != '0);

  mi_div_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (r),
    .divisor  (nr),
    .mult     (ntmag),
    .addend   (tmag),
    .done     (div_done),
    .rem      (div_rem),
    .acc      (div_acc)
  );

  // coefficient magnitude never exceeds the modulus, one subtract reduces it
  assign tsub    = tmag - {1'b0, m};
  assign coprime = (m != '0) && (r == DATA_WIDTH'(1));
  // even round count means the coefficient is non-positive
  assign inv_next = !coprime ? '0 :
                    (!idx && tmod != '0) ? m - tmod[DATA_WIDTH-1:0] :
                    tmod[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && dout.ready && (state != S_FINAL)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            r     <= din.modulus;
            nr    <= din.value;
            m     <= din.modulus;
            tmag  <= '0;
            ntmag <= (DATA_WIDTH + 1)'(1);
            idx   <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= div_start ? S_DIV : S_REDUCE;
        end
        S_DIV: begin
          if (div_done) begin
            tmag  <= ntmag;
            ntmag <= div_acc;
            r     <= nr;
            nr    <= div_rem;
            idx   <= ~idx;
            state <= S_CHECK;
          end
        end
        S_REDUCE: begin
          tmod  <= (tmag >= {1'b0, m}) ? tsub : tmag;
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (!out_valid || dout.ready) begin
            out_valid   <= 1'b1;
            out_inverse <= inv_next;
            out_exists  <= coprime;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !din.ready)
    else $error("ready still high after a word was taken");
  a_no_inverse_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_exists) |-> out_inverse == '0)
    else $error("inverse nonzero without an inverse");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && coprime) |-> inv_next < m)
    else $error("inverse not below modulus");
`endif

endmodule

// ===== sim/modular_inverse_test.sv =====
`timescale 1ns / 1ps

module modular_inverse_test;

  localparam int DW              = mi_pkg::MI_DATA_WIDTH;
  localparam int QUIET_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int RANDOM_WORDS    = 400;
  localparam int TAIL_CYCLES     = 2000;

  typedef logic [DW-1:0] word_t;

  typedef struct {
    word_t value;
    word_t modulus;
    word_t inverse;
    logic  exists;
  } inverse_entry_t;

  class inverse_scoreboard;
    inverse_entry_t pending_inverses[$];
    int unsigned    mismatches;
    int unsigned    noted;
    int unsigned    with_inverse;
    int unsigned    without_inverse;

    // extended euclid with sign tracked by step parity, magnitudes never exceed the modulus
    function inverse_entry_t predict_inverse(word_t value, word_t modulus);
      logic [63:0]    r, nr, t_mag, nt_mag, quo, tmp;
      bit             odd_step;
      inverse_entry_t res;
      res.value   = value;
      res.modulus = modulus;
      res.inverse = '0;
      res.exists  = 1'b0;
      if (modulus == '0) return res;
      r        = 64'(modulus);
      nr       = 64'(value);
      t_mag    = 64'd0;
      nt_mag   = 64'd1;
      odd_step = 1'b0;
      while (nr != 64'd0) begin
        quo      = r / nr;
        tmp      = t_mag + quo * nt_mag;
        t_mag    = nt_mag;
        nt_mag   = tmp;
        tmp      = r - quo * nr;
        r        = nr;
        nr       = tmp;
        odd_step = ~odd_step;
      end
      if (r != 64'd1) return res;
      t_mag = t_mag % 64'(modulus);
      if (!odd_step && t_mag != 64'd0) begin
        res.inverse = word_t'(64'(modulus) - t_mag);
      end else begin
        res.inverse = word_t'(t_mag);
      end
      res.exists = 1'b1;
      return res;
    endfunction

    function void note_word(word_t value, word_t modulus);
      pending_inverses.push_back(predict_inverse(value, modulus));
      noted++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 50) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_word(word_t inverse, logic exists);
      inverse_entry_t want;
      if (pending_inverses.size() == 0) begin
        report_mismatch($sformatf("unexpected result inverse=%0d exists=%0b",
                                  inverse, exists));
        return;
      end
      want = pending_inverses.pop_front();
      if (want.exists) with_inverse++;
      else without_inverse++;
      if (inverse !== want.inverse || exists !== want.exists) begin
        report_mismatch($sformatf(
          "value=%0d modulus=%0d: got inverse=%0d exists=%0b, want %0d/%0b",
          want.value, want.modulus, inverse, exists,
          want.inverse, want.exists));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  mi_in_if  #(.DATA_WIDTH(DW)) din ();
  mi_out_if #(.DATA_WIDTH(DW)) dout ();

  modular_inverse #(.DATA_WIDTH(DW)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always #4 clk = ~clk;

  inverse_scoreboard board = new();

  bit          hold_output = 1'b0;
  int unsigned hold_offs   = 0;
  int unsigned quiet       = 0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 300);
  endfunction

  function automatic word_t rand_field(int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return word_t'(raw & ((64'd1 << bits) - 64'd1));
  endfunction

  // handshake monitor: results first, then newly taken words
  always @(posedge clk) begin
    if (!rst) begin
      if (dout.valid && dout.ready) board.check_word(dout.inverse, dout.exists);
      if (din.valid && din.ready) board.note_word(din.value, din.modulus);
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result receiver with random stalls, calm stretches and long hold-offs
  initial begin
    int stall;
    int calm;
    calm = 0;
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        hold_offs++;
        stall = HOLD_OFF_CYCLES;
      end else if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = pick_gap();
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(100, 400);
      end
      if (stall > 0) begin
        dout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_word(word_t value, word_t modulus, int gap);
    din.valid   <= 1'b1;
    din.value   <= value;
    din.modulus <= modulus;
    do @(posedge clk); while (!din.ready);
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_word(int gap);
    word_t value;
    word_t modulus;
    int    kind;
    int    fbits;
    int    factor;
    kind  = $urandom_range(0, 9);
    fbits = (DW > 12) ? DW - 11 : 1;
    if (kind <= 5) begin
      value   = rand_field($urandom_range(1, DW));
      modulus = rand_field($urandom_range(1, DW));
    end else if (kind <= 7) begin
      // force a shared factor so the no-inverse path gets exercised
      factor  = $urandom_range(2, 1000);
      value   = word_t'(64'(factor) * 64'(rand_field(fbits)));
      modulus = word_t'(64'(factor) * 64'(rand_field(fbits)));
      if (modulus == '0) modulus = word_t'(factor);
    end else if (kind == 8) begin
      value   = rand_field(DW);
      modulus = rand_field(DW);
    end else begin
      value = rand_field(DW);
      case ($urandom_range(0, 2))
        0:       modulus = word_t'(1);
        1:       modulus = word_t'(2);
        default: modulus = '1;
      endcase
    end
    if (modulus == '0) modulus = word_t'(1);
    send_word(value, modulus, gap);
  endtask

  task automatic squeeze_output();
    hold_output = 1'b1;
    repeat (4) send_random_word(0);
  endtask

  initial begin
    word_t top;
    word_t msb;
    top = '1;
    msb = word_t'(64'd1 << (DW - 1));
    rst         <= 1'b1;
    din.valid   <= 1'b0;
    din.value   <= '0;
    din.modulus <= word_t'(1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners, back to back
    send_word('0, word_t'(1), 0);
    send_word('0, word_t'(7), 0);
    send_word('0, top, 0);
    send_word(word_t'(1), word_t'(1), 0);
    send_word(top, word_t'(1), 0);
    send_word(word_t'(1), word_t'(2), 0);
    send_word(word_t'(1), top, 0);
    send_word(word_t'(2), top, 0);
    send_word(top - word_t'(1), top, 0);
    send_word(top, top, 0);
    send_word(top, word_t'(2), 0);
    send_word(word_t'(10), word_t'(7), 0);
    send_word(word_t'(7), word_t'(7), 0);
    send_word(word_t'(6), word_t'(4), 0);
    send_word(word_t'(3), word_t'(4), 0);
    send_word(word_t'(12), word_t'(18), 0);
    send_word(word_t'(5), top - word_t'(1), 0);
    send_word(msb, top, 0);
    send_word(top, msb, 0);
    // consecutive fibonacci numbers give the longest run of rounds
    send_word(word_t'(1134903170), word_t'(1836311903), 0);
    send_word(word_t'(1836311903), word_t'(1134903170), 0);

    squeeze_output();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) squeeze_output();
      else send_random_word(pick_gap());
    end
    din.valid <= 1'b0;

    while (board.pending_inverses.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d with an inverse, %0d without",
             board.noted, board.with_inverse, board.without_inverse);
    $display("output held off %0d times while input kept coming", hold_offs);
    if (board.mismatches == 0 && board.pending_inverses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mi_pkg.sv
hdl/mi_if.sv
hdl/mi_div_unit.sv
hdl/modular_inverse.sv
sim/modular_inverse_test.sv
